// ----- rtl/core/vgrt_pkg.sv -----
// ----------------------------------------------------------------------------
// vgrt_pkg: shared constants and types
// Grid, fixed-point and field widths used by the voxel ray traversal block.
// ----------------------------------------------------------------------------
package vgrt_pkg;

  localparam int GRID_SIZE   = 32;
  localparam int FRAC_BITS   = 11;
  localparam int GRID_BITS   = $clog2(GRID_SIZE);
  localparam int COORD_W     = GRID_BITS + 1;
  localparam int ADDR_W      = 3 * GRID_BITS;

  localparam int POS_W       = 16;
  localparam int DIR_W       = 16;
  localparam int CELL_W      = 5;
  localparam int VAL_W       = 2;
  localparam int DIST_W      = 16;
  localparam int AXIS_W      = 2;
  localparam int ORG_CELL_W  = POS_W - FRAC_BITS;

  localparam int DIR_FRAC    = 14;
  localparam int MAG_W       = DIR_W;
  localparam int REM_W       = MAG_W + 1;
  localparam int QUOT_W      = DIR_FRAC + FRAC_BITS + 1;
  localparam int DELTA_SHIFT = 40;
  localparam int DELTA_W     = DELTA_SHIFT + 1;
  localparam int SIDE_W      = 48;

  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_CAST  = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [DIST_W-1:0] DIST_NO_LIMIT = {DIST_W{1'b1}};

  typedef struct packed {
    logic              hit;
    logic [CELL_W-1:0] hit_x;
    logic [CELL_W-1:0] hit_y;
    logic [CELL_W-1:0] hit_z;
    logic [CELL_W-1:0] prev_x;
    logic [CELL_W-1:0] prev_y;
    logic [CELL_W-1:0] prev_z;
    logic [AXIS_W-1:0] face_axis;
    logic [VAL_W-1:0]  hit_value;
    logic [DIST_W-1:0] hit_distance;
  } result_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_status_t;

endpackage

// ----- rtl/core/vgrt_if.sv -----
// ----------------------------------------------------------------------------
// vgrt_if: stream interfaces
// Valid/ready channels for the command input and the traversal result.
// ----------------------------------------------------------------------------
interface vgrt_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [vgrt_pkg::CELL_W-1:0] cell_x;
  logic [vgrt_pkg::CELL_W-1:0] cell_y;
  logic [vgrt_pkg::CELL_W-1:0] cell_z;
  logic [vgrt_pkg::VAL_W-1:0]  write_value;
  logic [vgrt_pkg::POS_W-1:0]  origin_x;
  logic [vgrt_pkg::POS_W-1:0]  origin_y;
  logic [vgrt_pkg::POS_W-1:0]  origin_z;
  logic signed [vgrt_pkg::DIR_W-1:0] dir_x;
  logic signed [vgrt_pkg::DIR_W-1:0] dir_y;
  logic signed [vgrt_pkg::DIR_W-1:0] dir_z;

  modport source (output valid, command, cell_x, cell_y, cell_z, write_value,
                  origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, command, cell_x, cell_y, cell_z, write_value,
                origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface vgrt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [vgrt_pkg::CELL_W-1:0] hit_x;
  logic [vgrt_pkg::CELL_W-1:0] hit_y;
  logic [vgrt_pkg::CELL_W-1:0] hit_z;
  logic [vgrt_pkg::CELL_W-1:0] prev_x;
  logic [vgrt_pkg::CELL_W-1:0] prev_y;
  logic [vgrt_pkg::CELL_W-1:0] prev_z;
  logic [vgrt_pkg::AXIS_W-1:0] face_axis;
  logic [vgrt_pkg::VAL_W-1:0]  hit_value;
  logic [vgrt_pkg::DIST_W-1:0] hit_distance;

  modport source (output valid, hit, hit_x, hit_y, hit_z, prev_x, prev_y, prev_z,
                  face_axis, hit_value, hit_distance, input ready);
  modport sink (input valid, hit, hit_x, hit_y, hit_z, prev_x, prev_y, prev_z,
                face_axis, hit_value, hit_distance, output ready);
endinterface

// ----- rtl/core/voxel_grid_ray_traversal.sv -----
// ----------------------------------------------------------------------------
// voxel_grid_ray_traversal: 3D DDA ray walk over a voxel store
// Stores voxel writes and walks cast rays cell by cell until a solid cell,
// the grid edge or the distance limit.
// ----------------------------------------------------------------------------
// A write transaction stores its value as it is accepted. A cast first sets up
// each axis in turn (one shared 26-bit divider and one multiplier), then walks
// cell by cell through S_STEP and S_CHECK, one voxel memory read per visited cell.
// Throughput: one transaction at a time; the next is taken once this one is done.
// Reset: synchronous; afterwards a clearing pass over all 32768 voxel addresses empties the
// voxel memory, during which no transaction is accepted.
module voxel_grid_ray_traversal (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [vgrt_pkg::DIST_W-1:0] cfg_wdata,
  vgrt_in_if.sink                     in_ch,
  vgrt_out_if.source                  out_ch
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV_GO, S_DIV_WAIT, S_MUL, S_START, S_STEP, S_CHECK
  } state_t;

  localparam int CW = vgrt_pkg::COORD_W;
  localparam int GB = vgrt_pkg::GRID_BITS;
  localparam int FB = vgrt_pkg::FRAC_BITS;

  state_t state;
  logic   done_pend;

  logic [vgrt_pkg::VAL_W-1:0] mem [2**vgrt_pkg::ADDR_W];
  logic [vgrt_pkg::VAL_W-1:0] rdata;
  logic [vgrt_pkg::ADDR_W-1:0] clr_addr;

  logic [vgrt_pkg::DIST_W-1:0] max_distance;
  logic [vgrt_pkg::POS_W-1:0]  origin [3];
  logic [vgrt_pkg::DIR_W-1:0]  dir [3];
  logic [CW-1:0]               cur [3];
  logic [CW-1:0]               prev [3];
  logic [vgrt_pkg::DELTA_W-1:0] delta [3];
  logic [vgrt_pkg::SIDE_W-1:0]  side [3];
  logic [1:0]                  k;
  logic [vgrt_pkg::SIDE_W-1:0] ray_dist;
  logic [vgrt_pkg::AXIS_W-1:0] axis;
  vgrt_pkg::result_t           res;
  vgrt_pkg::result_t           out_q;
  logic                        out_valid;

  logic                         div_start;
  vgrt_pkg::div_status_t        div_st;
  logic                         neg_k;
  logic [vgrt_pkg::MAG_W-1:0]   mag_k;
  logic [FB-1:0]                frac_k;
  logic [FB:0]                  factor_k;
  logic [FB+vgrt_pkg::QUOT_W:0] prod;
  logic [vgrt_pkg::SIDE_W-1:0]  side_calc;

  logic [vgrt_pkg::AXIS_W-1:0] sel;
  logic [CW-1:0]               nx, ny, nz;
  logic                        n_out;
  logic [vgrt_pkg::SIDE_W-1:0] sel_side;
  logic [vgrt_pkg::DELTA_W-1:0] sel_delta;
  logic                        go_on;
  logic                        in_acc;
  logic                        wr_ok;
  logic                        org_out;
  logic                        mem_we;
  logic [vgrt_pkg::ADDR_W-1:0] mem_waddr;
  logic [vgrt_pkg::VAL_W-1:0]  mem_wdata;

  vgrt_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (mag_k),
    .status  (div_st)
  );

  assign in_ch.ready = (state == S_IDLE) && !done_pend;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign div_start   = (state == S_DIV_GO) && (mag_k != '0);

  always_comb begin
    neg_k     = dir[k][vgrt_pkg::DIR_W-1];
    mag_k     = neg_k ? vgrt_pkg::MAG_W'(-dir[k]) : dir[k];
    frac_k    = origin[k][FB-1:0];
    factor_k  = neg_k ? {1'b0, frac_k} : (FB+1)'(1 << FB) - {1'b0, frac_k};
    prod      = factor_k * div_st.quot;
    if (mag_k == '0) begin
      side_calc = vgrt_pkg::SIDE_W'(factor_k) << (vgrt_pkg::DELTA_SHIFT - FB);
    end else begin
      side_calc = vgrt_pkg::SIDE_W'(prod >> FB);
    end
  end

  always_comb begin
    wr_ok = (int'(in_ch.cell_x) < vgrt_pkg::GRID_SIZE) &&
            (int'(in_ch.cell_y) < vgrt_pkg::GRID_SIZE) &&
            (int'(in_ch.cell_z) < vgrt_pkg::GRID_SIZE);
    org_out = (int'(in_ch.origin_x >> FB) >= vgrt_pkg::GRID_SIZE) ||
              (int'(in_ch.origin_y >> FB) >= vgrt_pkg::GRID_SIZE) ||
              (int'(in_ch.origin_z >> FB) >= vgrt_pkg::GRID_SIZE);
  end

  always_comb begin
    if (side[0] < side[1] && side[0] < side[2]) begin
      sel = vgrt_pkg::AXIS_X;
    end else if (side[1] < side[2]) begin
      sel = vgrt_pkg::AXIS_Y;
    end else begin
      sel = vgrt_pkg::AXIS_Z;
    end
    nx = cur[0];
    ny = cur[1];
    nz = cur[2];
    case (sel)
      vgrt_pkg::AXIS_X: begin
        sel_side  = side[0];
        sel_delta = delta[0];
        nx = dir[0][vgrt_pkg::DIR_W-1] ? cur[0] - 1'b1 : cur[0] + 1'b1;
      end
      vgrt_pkg::AXIS_Y: begin
        sel_side  = side[1];
        sel_delta = delta[1];
        ny = dir[1][vgrt_pkg::DIR_W-1] ? cur[1] - 1'b1 : cur[1] + 1'b1;
      end
      default: begin
        sel_side  = side[2];
        sel_delta = delta[2];
        nz = dir[2][vgrt_pkg::DIR_W-1] ? cur[2] - 1'b1 : cur[2] + 1'b1;
      end
    endcase
    n_out = (int'(nx) >= vgrt_pkg::GRID_SIZE) || (int'(ny) >= vgrt_pkg::GRID_SIZE) ||
            (int'(nz) >= vgrt_pkg::GRID_SIZE);
    go_on = (max_distance == vgrt_pkg::DIST_NO_LIMIT) ||
            (ray_dist < vgrt_pkg::SIDE_W'(max_distance));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (in_acc && in_ch.command == vgrt_pkg::CMD_WRITE && wr_ok) begin
      mem_we    = 1'b1;
      mem_waddr = {in_ch.cell_x[GB-1:0], in_ch.cell_y[GB-1:0], in_ch.cell_z[GB-1:0]};
      mem_wdata = in_ch.write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[{nx[GB-1:0], ny[GB-1:0], nz[GB-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= vgrt_pkg::DIST_NO_LIMIT;
    end else if (cfg_we) begin
      max_distance <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      done_pend <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (done_pend && (!out_valid || out_ch.ready)) begin
        out_q     <= res;
        out_valid <= 1'b1;
        done_pend <= 1'b0;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            res <= '0;
            if (in_ch.command == vgrt_pkg::CMD_WRITE || org_out) begin
              done_pend <= 1'b1;
            end else begin
              origin[0] <= in_ch.origin_x;
              origin[1] <= in_ch.origin_y;
              origin[2] <= in_ch.origin_z;
              dir[0]    <= in_ch.dir_x;
              dir[1]    <= in_ch.dir_y;
              dir[2]    <= in_ch.dir_z;
              cur[0]    <= CW'(in_ch.origin_x >> FB);
              cur[1]    <= CW'(in_ch.origin_y >> FB);
              cur[2]    <= CW'(in_ch.origin_z >> FB);
              k         <= '0;
              ray_dist  <= '0;
              state     <= S_DIV_GO;
            end
          end
        end
        S_DIV_GO: begin
          state <= (mag_k == '0) ? S_MUL : S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_st.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          side[k]  <= side_calc;
          delta[k] <= (mag_k == '0) ? vgrt_pkg::DELTA_W'(1) << vgrt_pkg::DELTA_SHIFT
                                    : vgrt_pkg::DELTA_W'(div_st.quot);
          if (k == 2'd2) begin
            state <= S_START;
          end else begin
            k     <= k + 1'b1;
            state <= S_DIV_GO;
          end
        end
        S_START: begin
          if (go_on) begin
            state <= S_STEP;
          end else begin
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_STEP: begin
          prev[0]  <= cur[0];
          prev[1]  <= cur[1];
          prev[2]  <= cur[2];
          cur[0]   <= nx;
          cur[1]   <= ny;
          cur[2]   <= nz;
          axis     <= sel;
          ray_dist <= sel_side;
          case (sel)
            vgrt_pkg::AXIS_X: side[0] <= sel_side + vgrt_pkg::SIDE_W'(sel_delta);
            vgrt_pkg::AXIS_Y: side[1] <= sel_side + vgrt_pkg::SIDE_W'(sel_delta);
            default:          side[2] <= sel_side + vgrt_pkg::SIDE_W'(sel_delta);
          endcase
          if (n_out) begin
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rdata != '0) begin
            res.hit          <= 1'b1;
            res.hit_x        <= vgrt_pkg::CELL_W'(cur[0]);
            res.hit_y        <= vgrt_pkg::CELL_W'(cur[1]);
            res.hit_z        <= vgrt_pkg::CELL_W'(cur[2]);
            res.prev_x       <= vgrt_pkg::CELL_W'(prev[0]);
            res.prev_y       <= vgrt_pkg::CELL_W'(prev[1]);
            res.prev_z       <= vgrt_pkg::CELL_W'(prev[2]);
            res.face_axis    <= axis;
            res.hit_value    <= rdata;
            res.hit_distance <= (ray_dist > vgrt_pkg::SIDE_W'(vgrt_pkg::DIST_NO_LIMIT))
                                ? vgrt_pkg::DIST_NO_LIMIT : ray_dist[vgrt_pkg::DIST_W-1:0];
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end else if (go_on) begin
            state <= S_STEP;
          end else begin
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.hit          = out_q.hit;
  assign out_ch.hit_x        = out_q.hit_x;
  assign out_ch.hit_y        = out_q.hit_y;
  assign out_ch.hit_z        = out_q.hit_z;
  assign out_ch.prev_x       = out_q.prev_x;
  assign out_ch.prev_y       = out_q.prev_y;
  assign out_ch.prev_z       = out_q.prev_z;
  assign out_ch.face_axis    = out_q.face_axis;
  assign out_ch.hit_value    = out_q.hit_value;
  assign out_ch.hit_distance = out_q.hit_distance;

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ch.ready)
    else $error("transaction accepted during the clearing pass");

  a_hit_solid: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.hit |-> out_ch.hit_value != '0)
    else $error("hit reported on an empty voxel");

  a_face_valid: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.face_axis != 2'd3)
    else $error("face axis out of range");

  a_valid_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(done_pend))
    else $error("result shown without a finished transaction");

endmodule

// ----- rtl/core/vgrt_div.sv -----
// ----------------------------------------------------------------------------
// vgrt_div: reciprocal divider
// Restoring divider computing 2^(QUOT_W-1) / divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module vgrt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [vgrt_pkg::MAG_W-1:0] divisor,
  output vgrt_pkg::div_status_t      status
);

  localparam int CNT_W = $clog2(vgrt_pkg::QUOT_W + 1);

  logic [vgrt_pkg::MAG_W-1:0]  dvs;
  logic [vgrt_pkg::REM_W-1:0]  rem;
  logic [vgrt_pkg::QUOT_W-1:0] quot;
  logic [CNT_W-1:0]            count;
  logic                        done;
  logic [vgrt_pkg::REM_W-1:0]  rem_sh;
  logic                        take;

  always_comb begin
    rem_sh = {rem[vgrt_pkg::REM_W-2:0],
              (count == CNT_W'(vgrt_pkg::QUOT_W))};
    take   = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CNT_W'(vgrt_pkg::QUOT_W);
        dvs   <= divisor;
        rem   <= '0;
        quot  <= '0;
      end else if (count != '0) begin
        rem   <= take ? rem_sh - {1'b0, dvs} : rem_sh;
        quot  <= {quot[vgrt_pkg::QUOT_W-2:0], take};
        count <= count - 1'b1;
        done  <= (count == CNT_W'(1));
      end
    end
  end

  assign status.done = done;
  assign status.quot = quot;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: voxel grid ray traversal testbench
// Fills the voxel store with writes and casts rays through it. Every cast
// on the input channel is predicted with a fixed-point 3D DDA walk, every write with an empty result.
// Every transaction on the result channel is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic                        command;
    logic [vgrt_pkg::CELL_W-1:0] cell_x, cell_y, cell_z;
    logic [vgrt_pkg::VAL_W-1:0]  write_value;
    logic [vgrt_pkg::POS_W-1:0]  origin_x, origin_y, origin_z;
    logic [vgrt_pkg::DIR_W-1:0]  dir_x, dir_y, dir_z;
  } command_item_t;

  class ray_scoreboard;
    bit [vgrt_pkg::VAL_W-1:0]    voxel_mem[vgrt_pkg::GRID_SIZE * vgrt_pkg::GRID_SIZE *
                                           vgrt_pkg::GRID_SIZE];
    logic [vgrt_pkg::DIST_W-1:0] dist_limit;
    vgrt_pkg::result_t           pending_hits[$];
    int                          errors;

    function new();
      dist_limit = vgrt_pkg::DIST_NO_LIMIT;
      errors = 0;
    endfunction

    function void set_limit(logic [vgrt_pkg::DIST_W-1:0] v);
      dist_limit = v;
    endfunction

    function automatic void axis_start(input logic [vgrt_pkg::POS_W-1:0] org,
                                       input logic [vgrt_pkg::DIR_W-1:0] dir,
                                       output int cell_idx,
                                       output int stp, output longint unsigned dlt,
                                       output longint unsigned sd);
      longint unsigned frac, mag;
      frac = org[vgrt_pkg::FRAC_BITS-1:0];
      mag = dir[vgrt_pkg::DIR_W-1] ? (64'd65536 - dir) : dir;
      cell_idx = int'(org >> vgrt_pkg::FRAC_BITS);
      dlt = (mag == 0) ? (64'd1 << 40)
                       : ((64'd1 << (vgrt_pkg::DIR_FRAC + vgrt_pkg::FRAC_BITS)) / mag);
      if (dir[vgrt_pkg::DIR_W-1]) begin
        stp = -1;
        sd = (frac * dlt) >> vgrt_pkg::FRAC_BITS;
      end else begin
        stp = 1;
        sd = (((64'd1 << vgrt_pkg::FRAC_BITS) - frac) * dlt) >> vgrt_pkg::FRAC_BITS;
      end
    endfunction

    function void note_command(command_item_t c);
      vgrt_pkg::result_t r;
      int cur[3], prv[3], stp[3];
      longint unsigned dlt[3], sd[3], ray_dist;
      int ax;
      bit solid, gone;
      r = '0;
      if (c.command == vgrt_pkg::CMD_WRITE) begin
        voxel_mem[{c.cell_x, c.cell_y, c.cell_z}] = c.write_value;
        pending_hits.push_back(r);
        return;
      end
      axis_start(c.origin_x, c.dir_x, cur[0], stp[0], dlt[0], sd[0]);
      axis_start(c.origin_y, c.dir_y, cur[1], stp[1], dlt[1], sd[1]);
      axis_start(c.origin_z, c.dir_z, cur[2], stp[2], dlt[2], sd[2]);
      ray_dist = 0;
      ax = 0;
      solid = 0;
      gone = 0;
      while (!solid && !gone &&
             (dist_limit == vgrt_pkg::DIST_NO_LIMIT || ray_dist < dist_limit)) begin
        prv = cur;
        if (sd[0] < sd[1] && sd[0] < sd[2]) ax = 0;
        else if (sd[1] < sd[2]) ax = 1;
        else ax = 2;
        ray_dist = sd[ax];
        sd[ax] += dlt[ax];
        cur[ax] += stp[ax];
        for (int k = 0; k < 3; k++)
          if (cur[k] < 0 || cur[k] >= vgrt_pkg::GRID_SIZE) gone = 1;
        if (!gone && voxel_mem[cur[0]*1024 + cur[1]*32 + cur[2]] != 0) solid = 1;
      end
      if (solid) begin
        r.hit = 1'b1;
        r.hit_x = vgrt_pkg::CELL_W'(cur[0]);
        r.hit_y = vgrt_pkg::CELL_W'(cur[1]);
        r.hit_z = vgrt_pkg::CELL_W'(cur[2]);
        r.prev_x = vgrt_pkg::CELL_W'(prv[0]);
        r.prev_y = vgrt_pkg::CELL_W'(prv[1]);
        r.prev_z = vgrt_pkg::CELL_W'(prv[2]);
        r.face_axis = (ax == 0) ? vgrt_pkg::AXIS_X :
                      (ax == 1) ? vgrt_pkg::AXIS_Y : vgrt_pkg::AXIS_Z;
        r.hit_value = voxel_mem[cur[0]*1024 + cur[1]*32 + cur[2]];
        r.hit_distance = (ray_dist > 65535) ? 16'hFFFF : ray_dist[15:0];
      end
      pending_hits.push_back(r);
    endfunction

    function void compare_field(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(vgrt_pkg::result_t a);
      vgrt_pkg::result_t e;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, a);
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      compare_field("hit", e.hit, a.hit);
      compare_field("hit_x", e.hit_x, a.hit_x);
      compare_field("hit_y", e.hit_y, a.hit_y);
      compare_field("hit_z", e.hit_z, a.hit_z);
      compare_field("prev_x", e.prev_x, a.prev_x);
      compare_field("prev_y", e.prev_y, a.prev_y);
      compare_field("prev_z", e.prev_z, a.prev_z);
      compare_field("face_axis", e.face_axis, a.face_axis);
      compare_field("hit_value", e.hit_value, a.hit_value);
      compare_field("hit_distance", e.hit_distance, a.hit_distance);
    endfunction
  endclass

  logic clk, rst, cfg_we;
  logic [vgrt_pkg::DIST_W-1:0] cfg_wdata;
  vgrt_in_if  in_ch();
  vgrt_out_if out_ch();
  ray_scoreboard sb;
  bit quiet, hold_request;
  int idle_cycles;
  int region;

  voxel_grid_ray_traversal DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      sb.note_command('{in_ch.command, in_ch.cell_x, in_ch.cell_y, in_ch.cell_z,
                        in_ch.write_value, in_ch.origin_x, in_ch.origin_y,
                        in_ch.origin_z, in_ch.dir_x, in_ch.dir_y, in_ch.dir_z});
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.hit, out_ch.hit_x, out_ch.hit_y, out_ch.hit_z,
                        out_ch.prev_x, out_ch.prev_y, out_ch.prev_z,
                        out_ch.face_axis, out_ch.hit_value, out_ch.hit_distance});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= 100000) begin
      $display("voxel_grid_ray_traversal test failed");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_ch.ready = 0;
        hold_request = 0;
        repeat (1500) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_ch.ready = 1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  task automatic send_command(command_item_t c);
    @(negedge clk);
    in_ch.valid = 1;
    in_ch.command = c.command;
    in_ch.cell_x = c.cell_x;
    in_ch.cell_y = c.cell_y;
    in_ch.cell_z = c.cell_z;
    in_ch.write_value = c.write_value;
    in_ch.origin_x = c.origin_x;
    in_ch.origin_y = c.origin_y;
    in_ch.origin_z = c.origin_z;
    in_ch.dir_x = c.dir_x;
    in_ch.dir_y = c.dir_y;
    in_ch.dir_z = c.dir_z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        in_ch.valid = 0;
      end
    end
  endtask

  task automatic write_voxel(int x, int y, int z, int v);
    command_item_t c;
    c = '{vgrt_pkg::CMD_WRITE, vgrt_pkg::CELL_W'(x), vgrt_pkg::CELL_W'(y),
          vgrt_pkg::CELL_W'(z), vgrt_pkg::VAL_W'(v),
          vgrt_pkg::POS_W'($urandom), vgrt_pkg::POS_W'($urandom),
          vgrt_pkg::POS_W'($urandom), vgrt_pkg::DIR_W'($urandom),
          vgrt_pkg::DIR_W'($urandom), vgrt_pkg::DIR_W'($urandom)};
    send_command(c);
  endtask

  task automatic cast_ray(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                          logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
    command_item_t c;
    c = '{vgrt_pkg::CMD_CAST, vgrt_pkg::CELL_W'($urandom), vgrt_pkg::CELL_W'($urandom),
          vgrt_pkg::CELL_W'($urandom), vgrt_pkg::VAL_W'($urandom),
          ox, oy, oz, dx, dy, dz};
    send_command(c);
  endtask

  task automatic drain_and_configure(logic [vgrt_pkg::DIST_W-1:0] v);
    @(negedge clk);
    in_ch.valid = 0;
    while (sb.pending_hits.size() != 0) @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    sb.set_limit(v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic int pick_cell();
    return ($urandom_range(0, 3) != 0) ? region + int'($urandom_range(0, 7))
                                       : int'($urandom_range(0, 31));
  endfunction

  function automatic logic [15:0] pick_dir();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return $urandom_range(0, 3) == 0 ? 16'h4000 : 16'hC000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_origin();
    logic [4:0] cell_idx;
    cell_idx = 5'(pick_cell());
    return {cell_idx, 11'($urandom)};
  endfunction

  initial begin
    logic [vgrt_pkg::DIST_W-1:0] limits[8];
    sb = new();
    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    in_ch.valid = 0;
    in_ch.command = vgrt_pkg::CMD_WRITE;
    {in_ch.cell_x, in_ch.cell_y, in_ch.cell_z, in_ch.write_value} = '0;
    {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z} = '0;
    {in_ch.dir_x, in_ch.dir_y, in_ch.dir_z} = '0;
    quiet = 0;
    hold_request = 0;
    idle_cycles = 0;
    region = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    drain_and_configure(vgrt_pkg::DIST_NO_LIMIT);

    // Directed rays through a few walls, including corner origins, steep axes and distance limits.
    cast_ray(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    write_voxel(31, 31, 31, 3);
    write_voxel(0, 0, 5, 1);
    write_voxel(0, 0, 0, 2);
    write_voxel(16, 16, 20, 2);
    cast_ray(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    cast_ray(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000);
    cast_ray(16'hF800, 16'hF800, 16'hE000, 16'h0000, 16'h0000, 16'h7FFF);
    cast_ray(16'h8400, 16'h8400, 16'h8400, 16'h0000, 16'h0000, 16'h4000);
    cast_ray(16'h8400, 16'h8400, 16'hC7FF, 16'h0000, 16'h0000, 16'hC000);
    cast_ray(16'h0400, 16'h0400, 16'h0400, 16'h2D41, 16'h2D41, 16'h2D41);
    write_voxel(0, 0, 5, 0);
    cast_ray(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    cast_ray(16'h07FF, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001);
    drain_and_configure(16'd0);
    cast_ray(16'h8400, 16'h8400, 16'h8400, 16'h0000, 16'h0000, 16'h4000);
    drain_and_configure(16'd1);
    cast_ray(16'h8400, 16'h8400, 16'h8400, 16'h0000, 16'h0000, 16'h4000);
    cast_ray(16'h8400, 16'h8400, 16'h8400, 16'h0000, 16'h0000, 16'hC000);
    drain_and_configure(16'd2048);
    cast_ray(16'h8400, 16'h8400, 16'h8400, 16'h0000, 16'h0000, 16'h4000);
    cast_ray(16'h8400, 16'h8400, 16'h8400, 16'h0000, 16'h0000, 16'h1000);

    limits = '{16'hFFFF, 16'd0, 16'd4000, 16'hFFFE, 16'd1, 16'd20000, 16'hFFFF, 16'hFFFF};
    for (int phase = 0; phase < 8; phase++) begin
      drain_and_configure(phase == 2 ? 16'($urandom_range(0, 30000)) : limits[phase]);
      region = int'($urandom_range(0, 24));
      quiet = (phase == 7);
      for (int n = 0; n < 200; n++) begin
        if (phase == 3 && n == 20) hold_request = 1;
        if ($urandom_range(0, 9) < 3)
          write_voxel(pick_cell(), pick_cell(), pick_cell(),
                      $urandom_range(0, 4) == 0 ? 0 : int'($urandom_range(1, 3)));
        else
          cast_ray(pick_origin(), pick_origin(), pick_origin(),
                   pick_dir(), pick_dir(), pick_dir());
      end
    end

    @(negedge clk);
    in_ch.valid = 0;
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0)
      $display("voxel_grid_ray_traversal test passed");
    else
      $display("voxel_grid_ray_traversal test failed");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/vgrt_pkg.sv
rtl/core/vgrt_if.sv
rtl/core/vgrt_div.sv
rtl/core/voxel_grid_ray_traversal.sv
sim/tb.sv
